// ===== rtl/core/rv64_control_transfer_emulator_macros.svh =====
// Assertion macros shared by the control transfer emulator RTL.
`ifndef RV64_CONTROL_TRANSFER_EMULATOR_MACROS_SVH
`define RV64_CONTROL_TRANSFER_EMULATOR_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property on every clock edge outside reset.
`define RVCTE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rvcte assertion failed");
// Checks a property whenever the enabling condition holds outside reset.
`define RVCTE_ASSERT_WHEN(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rvcte assertion failed");
`else
`define RVCTE_ASSERT(label, prop)
`define RVCTE_ASSERT_WHEN(label, cond, prop)
`endif
`endif

// ===== rtl/core/rvcte_pkg.sv =====
// Shared types, opcodes and decode function of the control transfer emulator.
package rvcte_pkg;

    // Width of the address and register fields on the ports.
    localparam int unsigned DATA_W = 64;
    localparam int unsigned XLEN_DEFAULT = 64;

    // Result kinds.
    typedef enum logic [3:0] {
        K_OTHER  = 4'd0,
        K_EBREAK = 4'd1,
        K_AUIPC  = 4'd2,
        K_JAL    = 4'd3,
        K_JALR   = 4'd4,
        K_BRANCH = 4'd5,
        K_CJ     = 4'd6,
        K_CBEQZ  = 4'd7,
        K_CBNEZ  = 4'd8,
        K_CJR    = 4'd9,
        K_CJALR  = 4'd10
    } kind_t;

    // Instruction encodings.
    localparam logic [31:0] EBREAK_WORD  = 32'h0010_0073;
    localparam logic [15:0] C_EBREAK_HW  = 16'h9002;
    localparam logic [6:0]  OP_AUIPC     = 7'h17;
    localparam logic [6:0]  OP_JAL       = 7'h6f;
    localparam logic [6:0]  OP_JALR      = 7'h67;
    localparam logic [6:0]  OP_BRANCH    = 7'h63;
    localparam logic [1:0]  OP_WIDE      = 2'b11;
    localparam logic [1:0]  C_OP_Q1      = 2'b01;
    localparam logic [1:0]  C_OP_Q2      = 2'b10;
    localparam logic [2:0]  C_F3_J       = 3'd5;
    localparam logic [2:0]  C_F3_BEQZ    = 3'd6;
    localparam logic [2:0]  C_F3_BNEZ    = 3'd7;
    localparam logic [2:0]  C_F3_JR      = 3'd4;

    // Branch conditions.
    localparam logic [2:0]  F3_BEQ  = 3'd0;
    localparam logic [2:0]  F3_BNE  = 3'd1;
    localparam logic [2:0]  F3_BLT  = 3'd4;
    localparam logic [2:0]  F3_BGE  = 3'd5;
    localparam logic [2:0]  F3_BLTU = 3'd6;
    localparam logic [2:0]  F3_BGEU = 3'd7;

    // Register numbers and lengths.
    localparam logic [4:0]  REG_ZERO = 5'd0;
    localparam logic [4:0]  REG_RA   = 5'd1;
    localparam logic [2:0]  LEN_WIDE = 3'd4;
    localparam logic [2:0]  LEN_COMP = 3'd2;

    // Control carried out of the decode stage.
    typedef struct packed {
        kind_t      kind;
        logic       wide;
        logic [4:0] rd;
        logic       wr;
        logic [2:0] funct3;
        logic       base_rs1;
    } dec_ctrl_t;

    // Control carried out of the execute stage.
    typedef struct packed {
        kind_t      kind;
        logic       wide;
        logic [4:0] rd;
        logic       wr;
        logic       taken;
    } exe_ctrl_t;

    // Classifies an instruction word.
    function automatic kind_t kind_of(logic [31:0] w);
        logic [15:0] h;
        kind_t       k;
        h = w[15:0];
        k = K_OTHER;
        if (w[1:0] == OP_WIDE) begin
            if (w == EBREAK_WORD) begin
                k = K_EBREAK;
            end
            else begin
                case (w[6:0])
                    OP_AUIPC:  k = K_AUIPC;
                    OP_JAL:    k = K_JAL;
                    OP_JALR:   k = K_JALR;
                    OP_BRANCH: k = K_BRANCH;
                    default:   k = K_OTHER;
                endcase
            end
        end
        else if (h == C_EBREAK_HW) begin
            k = K_EBREAK;
        end
        else if (h[1:0] == C_OP_Q1) begin
            case (h[15:13])
                C_F3_J:    k = K_CJ;
                C_F3_BEQZ: k = K_CBEQZ;
                C_F3_BNEZ: k = K_CBNEZ;
                default:   k = K_OTHER;
            endcase
        end
        else if (h[1:0] == C_OP_Q2 && h[15:13] == C_F3_JR
                 && h[6:2] == REG_ZERO && h[11:7] != REG_ZERO) begin
            k = h[12] ? K_CJALR : K_CJR;
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/rvcte_decode.sv =====
// First pipeline stage: classification, immediate assembly and operand capture.
module rvcte_decode #(
    parameter int unsigned XLEN = rvcte_pkg::XLEN_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  logic [31:0]           instruction,
    input  logic [XLEN-1:0]       pc_in,
    input  logic [XLEN-1:0]       a_in,
    input  logic [XLEN-1:0]       b_in,
    output logic                  valid_reg,
    output rvcte_pkg::dec_ctrl_t  ctrl_reg,
    output logic [XLEN-1:0]       pc_reg,
    output logic [XLEN-1:0]       a_reg,
    output logic [XLEN-1:0]       b_reg,
    output logic [XLEN-1:0]       imm_reg
);

    rvcte_pkg::kind_t     kind;
    rvcte_pkg::dec_ctrl_t ctrl_next;
    logic [XLEN-1:0]      imm_next;
    logic [4:0]           rd_raw;
    logic                 wr_raw;
    logic [31:0]          w;
    logic [20:0]          imm_j;
    logic [12:0]          imm_b;
    logic [11:0]          imm_cj;
    logic [8:0]           imm_cb;

    assign w    = instruction;
    assign kind = rvcte_pkg::kind_of(w);

    // Immediate fields of each format, before sign extension.
    assign imm_j  = {w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign imm_b  = {w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_cj = {w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
    assign imm_cb = {w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0};

    // Immediate selection and destination decode by kind.
    always_comb
    begin
        imm_next = '0;
        rd_raw   = w[11:7];
        wr_raw   = 1'b0;
        case (kind)
            rvcte_pkg::K_AUIPC:
            begin
                imm_next = {{(XLEN-32){w[31]}}, w[31:12], 12'h000};
                wr_raw   = 1'b1;
            end
            rvcte_pkg::K_JAL:
            begin
                imm_next = {{(XLEN-21){imm_j[20]}}, imm_j};
                wr_raw   = 1'b1;
            end
            rvcte_pkg::K_JALR:
            begin
                imm_next = {{(XLEN-12){w[31]}}, w[31:20]};
                wr_raw   = 1'b1;
            end
            rvcte_pkg::K_BRANCH:
            begin
                imm_next = {{(XLEN-13){imm_b[12]}}, imm_b};
            end
            rvcte_pkg::K_CJ:
            begin
                imm_next = {{(XLEN-12){imm_cj[11]}}, imm_cj};
            end
            rvcte_pkg::K_CBEQZ, rvcte_pkg::K_CBNEZ:
            begin
                imm_next = {{(XLEN-9){imm_cb[8]}}, imm_cb};
            end
            rvcte_pkg::K_CJALR:
            begin
                rd_raw = rvcte_pkg::REG_RA;
                wr_raw = 1'b1;
            end
            default:
            begin
                imm_next = '0;
            end
        endcase
    end

    // Pack the control word; a write to x0 is dropped here.
    always_comb
    begin
        ctrl_next.kind     = kind;
        ctrl_next.wide     = (w[1:0] == rvcte_pkg::OP_WIDE);
        ctrl_next.wr       = wr_raw && (rd_raw != rvcte_pkg::REG_ZERO);
        ctrl_next.rd       = ctrl_next.wr ? rd_raw : rvcte_pkg::REG_ZERO;
        ctrl_next.funct3   = w[14:12];
        ctrl_next.base_rs1 = (kind inside {rvcte_pkg::K_JALR, rvcte_pkg::K_CJR,
                                           rvcte_pkg::K_CJALR});
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= valid_in;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en) begin
            ctrl_reg <= ctrl_next;
            pc_reg   <= pc_in;
            a_reg    <= a_in;
            b_reg    <= b_in;
            imm_reg  <= imm_next;
        end
    end

endmodule

// ===== rtl/core/rvcte_execute.sv =====
// Second pipeline stage: target and link adders and the branch compare.
module rvcte_execute #(
    parameter int unsigned XLEN = rvcte_pkg::XLEN_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  rvcte_pkg::dec_ctrl_t  ctrl_in,
    input  logic [XLEN-1:0]       pc_in,
    input  logic [XLEN-1:0]       a_in,
    input  logic [XLEN-1:0]       b_in,
    input  logic [XLEN-1:0]       imm_in,
    output logic                  valid_reg,
    output rvcte_pkg::exe_ctrl_t  ctrl_reg,
    output logic [XLEN-1:0]       target_reg,
    output logic [XLEN-1:0]       link_reg
);

    logic [XLEN-1:0]      base;
    logic [XLEN-1:0]      target_next;
    logic [XLEN-1:0]      link_next;
    logic [XLEN-1:0]      step;
    logic                 cond;
    logic                 taken_next;
    rvcte_pkg::exe_ctrl_t ctrl_next;

    // Target is base plus immediate; link is pc plus the length.
    assign base        = ctrl_in.base_rs1 ? a_in : pc_in;
    assign target_next = base + imm_in;
    assign step        = XLEN'(ctrl_in.wide ? rvcte_pkg::LEN_WIDE : rvcte_pkg::LEN_COMP);
    assign link_next   = pc_in + step;

    // Branch condition; the two unused funct3 codes never take.
    always_comb
    begin
        case (ctrl_in.funct3)
            rvcte_pkg::F3_BEQ:  cond = (a_in == b_in);
            rvcte_pkg::F3_BNE:  cond = (a_in != b_in);
            rvcte_pkg::F3_BLT:  cond = ($signed(a_in) < $signed(b_in));
            rvcte_pkg::F3_BGE:  cond = ($signed(a_in) >= $signed(b_in));
            rvcte_pkg::F3_BLTU: cond = (a_in < b_in);
            rvcte_pkg::F3_BGEU: cond = (a_in >= b_in);
            default:            cond = 1'b0;
        endcase
    end

    // Taken decision by kind.
    always_comb
    begin
        case (ctrl_in.kind)
            rvcte_pkg::K_BRANCH: taken_next = cond;
            rvcte_pkg::K_CBEQZ:  taken_next = (a_in == '0);
            rvcte_pkg::K_CBNEZ:  taken_next = (a_in != '0);
            default:             taken_next = 1'b0;
        endcase
    end

    always_comb
    begin
        ctrl_next.kind  = ctrl_in.kind;
        ctrl_next.wide  = ctrl_in.wide;
        ctrl_next.rd    = ctrl_in.rd;
        ctrl_next.wr    = ctrl_in.wr;
        ctrl_next.taken = taken_next;
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= valid_in;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en) begin
            ctrl_reg   <= ctrl_next;
            target_reg <= target_next;
            link_reg   <= link_next;
        end
    end

endmodule

// ===== rtl/core/rvcte_retire.sv =====
// Third pipeline stage: next pc and register write selection into the output register.
module rvcte_retire #(
    parameter int unsigned XLEN = rvcte_pkg::XLEN_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  rvcte_pkg::exe_ctrl_t  ctrl_in,
    input  logic [XLEN-1:0]       target_in,
    input  logic [XLEN-1:0]       link_in,
    output logic                  valid_reg,
    output rvcte_pkg::kind_t      kind_reg,
    output logic [2:0]            len_reg,
    output logic [XLEN-1:0]       npc_reg,
    output logic                  taken_reg,
    output logic                  wr_reg,
    output logic [4:0]            rd_reg,
    output logic [XLEN-1:0]       rval_reg
);

    logic [XLEN-1:0] npc_next;
    logic [XLEN-1:0] rval_next;

    // Next pc by kind; register jumps clear bit 0 of the target.
    always_comb
    begin
        case (ctrl_in.kind)
            rvcte_pkg::K_JAL, rvcte_pkg::K_CJ:
                npc_next = target_in;
            rvcte_pkg::K_JALR, rvcte_pkg::K_CJR, rvcte_pkg::K_CJALR:
                npc_next = {target_in[XLEN-1:1], 1'b0};
            rvcte_pkg::K_BRANCH, rvcte_pkg::K_CBEQZ, rvcte_pkg::K_CBNEZ:
                npc_next = ctrl_in.taken ? target_in : link_in;
            default:
                npc_next = link_in;
        endcase
    end

    // Written value: zero without a write, pc plus immediate for auipc, otherwise the link address.
    always_comb
    begin
        if (!ctrl_in.wr) begin
            rval_next = '0;
        end
        else if (ctrl_in.kind == rvcte_pkg::K_AUIPC) begin
            rval_next = target_in;
        end
        else begin
            rval_next = link_in;
        end
    end

    // Output valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= valid_in;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (en) begin
            kind_reg  <= ctrl_in.kind;
            len_reg   <= ctrl_in.wide ? rvcte_pkg::LEN_WIDE : rvcte_pkg::LEN_COMP;
            npc_reg   <= npc_next;
            taken_reg <= ctrl_in.taken;
            wr_reg    <= ctrl_in.wr;
            rd_reg    <= ctrl_in.rd;
            rval_reg  <= rval_next;
        end
    end

endmodule

// ===== rtl/core/rv64_control_transfer_emulator.sv =====
// Top level of the RISC-V branch and jump emulation pipeline.
//
// Takes one instruction item per cycle, unless in_stall is high, through three
// register stages: decode, then the target and link adders with the branch
// compare, then next-pc and write selection into the output register. The
// result item shows on the outputs from the retire register and leaves once
// out_stall is low. All address arithmetic and signed compares are done at
// XLEN bits; the 64-bit ports carry the low XLEN bits and zero above. Each
// stage holds its item while the stage behind it is full and stalled, so
// in_stall follows out_stall back through the three valid bits in the same
// cycle, and a full pipeline keeps streaming one item per cycle as long as
// out_stall stays low.
`include "rv64_control_transfer_emulator_macros.svh"

module rv64_control_transfer_emulator #(
    parameter int unsigned XLEN = rvcte_pkg::XLEN_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instruction,
    input  logic [63:0] pc,
    input  logic [63:0] rs1_value,
    input  logic [63:0] rs2_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  kind,
    output logic [2:0]  inst_len,
    output logic [63:0] next_pc,
    output logic        branch_taken,
    output logic        reg_write,
    output logic [4:0]  reg_index,
    output logic [63:0] reg_value
);

    localparam int unsigned DW = rvcte_pkg::DATA_W;

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic                 adv1;
    logic                 adv2;
    logic                 adv3;
    rvcte_pkg::dec_ctrl_t dctrl_reg;
    rvcte_pkg::exe_ctrl_t ectrl_reg;
    logic [XLEN-1:0]      pc1_reg;
    logic [XLEN-1:0]      a1_reg;
    logic [XLEN-1:0]      b1_reg;
    logic [XLEN-1:0]      imm1_reg;
    logic [XLEN-1:0]      target2_reg;
    logic [XLEN-1:0]      link2_reg;
    rvcte_pkg::kind_t     kind_reg;
    logic [2:0]           len_reg;
    logic [XLEN-1:0]      npc_reg;
    logic                 taken_reg;
    logic                 wr_reg;
    logic [4:0]           rd_reg;
    logic [XLEN-1:0]      rval_reg;

    // A stage moves when it is empty or the stage behind it moves.
    assign adv3     = !v3_reg || !out_stall;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    rvcte_decode #(
        .XLEN (XLEN)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv1),
        .valid_in    (in_valid),
        .instruction (instruction),
        .pc_in       (pc[XLEN-1:0]),
        .a_in        (rs1_value[XLEN-1:0]),
        .b_in        (rs2_value[XLEN-1:0]),
        .valid_reg   (v1_reg),
        .ctrl_reg    (dctrl_reg),
        .pc_reg      (pc1_reg),
        .a_reg       (a1_reg),
        .b_reg       (b1_reg),
        .imm_reg     (imm1_reg)
    );

    rvcte_execute #(
        .XLEN (XLEN)
    ) u_execute (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv2),
        .valid_in   (v1_reg),
        .ctrl_in    (dctrl_reg),
        .pc_in      (pc1_reg),
        .a_in       (a1_reg),
        .b_in       (b1_reg),
        .imm_in     (imm1_reg),
        .valid_reg  (v2_reg),
        .ctrl_reg   (ectrl_reg),
        .target_reg (target2_reg),
        .link_reg   (link2_reg)
    );

    rvcte_retire #(
        .XLEN (XLEN)
    ) u_retire (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv3),
        .valid_in  (v2_reg),
        .ctrl_in   (ectrl_reg),
        .target_in (target2_reg),
        .link_in   (link2_reg),
        .valid_reg (v3_reg),
        .kind_reg  (kind_reg),
        .len_reg   (len_reg),
        .npc_reg   (npc_reg),
        .taken_reg (taken_reg),
        .wr_reg    (wr_reg),
        .rd_reg    (rd_reg),
        .rval_reg  (rval_reg)
    );

    // Result ports, widened to the port width.
    assign out_valid    = v3_reg;
    assign kind         = kind_reg;
    assign inst_len     = len_reg;
    assign next_pc      = DW'(npc_reg);
    assign branch_taken = taken_reg;
    assign reg_write    = wr_reg;
    assign reg_index    = rd_reg;
    assign reg_value    = DW'(rval_reg);

    // The input side only stalls when the decode stage holds an item.
    `RVCTE_ASSERT_WHEN(a_stall_needs_item, in_stall, v1_reg)
    // A register write never targets x0.
    `RVCTE_ASSERT_WHEN(a_no_x0_write, out_valid && reg_write, reg_index != rvcte_pkg::REG_ZERO)
    // Without a write, the index and value read as zero.
    `RVCTE_ASSERT_WHEN(a_idle_write_zero, out_valid && !reg_write,
        reg_index == rvcte_pkg::REG_ZERO && reg_value == '0)
    // Only conditional branches report taken.
    `RVCTE_ASSERT_WHEN(a_taken_kind, out_valid && branch_taken,
        kind == rvcte_pkg::K_BRANCH || kind == rvcte_pkg::K_CBEQZ
        || kind == rvcte_pkg::K_CBNEZ)
    // Compressed control transfers are two bytes long.
    `RVCTE_ASSERT_WHEN(a_compressed_len,
        out_valid && (kind == rvcte_pkg::K_CJ || kind == rvcte_pkg::K_CJR
        || kind == rvcte_pkg::K_CJALR || kind == rvcte_pkg::K_CBEQZ
        || kind == rvcte_pkg::K_CBNEZ),
        inst_len == rvcte_pkg::LEN_COMP)

endmodule

// ===== test/rv64_control_transfer_emulator_tb.sv =====
// Testbench for the RV64 branch and jump emulator with directed, random items and scoreboard.
`timescale 1ns / 100ps

module rv64_control_transfer_emulator_tb;

    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    // One instruction item as offered to the block.
    typedef struct {
        logic [31:0] word;
        logic [63:0] pc;
        logic [63:0] src1;
        logic [63:0] src2;
    } xfer_in_t;

    // One result item as returned by the block.
    typedef struct {
        rvcte_pkg::kind_t kind;
        logic [2:0]       len;
        logic [63:0]      next_pc;
        logic             taken;
        logic             wr;
        logic [4:0]       rd;
        logic [63:0]      value;
    } xfer_res_t;

    // Expected result together with the word that produced it.
    typedef struct {
        xfer_res_t   res;
        logic [31:0] word;
    } pending_xfer_t;

    // Scoreboard: predicts each accepted instruction and matches results in order.
    class transfer_scoreboard;
        pending_xfer_t expected_results[$];
        int errors;
        int accepted;
        int checked;
        int taken_seen;
        int writes_seen;
        int kind_hits[16];

        task report(string what);
            errors++;
            if (errors <= 40) begin
                $display("MISMATCH at %0t ns: %s", $time, what);
            end
        endtask

        // Works out kind, next pc and register write for one instruction.
        function xfer_res_t resolve_transfer(xfer_in_t it);
            xfer_res_t   r;
            logic [31:0] w;
            logic [15:0] h;
            logic [63:0] seq_pc;
            w = it.word;
            h = w[15:0];
            r.len = (w[1:0] == rvcte_pkg::OP_WIDE) ? rvcte_pkg::LEN_WIDE : rvcte_pkg::LEN_COMP;
            seq_pc = it.pc + {61'd0, r.len};
            r.kind = rvcte_pkg::K_OTHER;
            r.next_pc = seq_pc;
            r.taken = 1'b0;
            r.wr = 1'b0;
            r.rd = rvcte_pkg::REG_ZERO;
            r.value = 64'd0;
            if (w[1:0] == rvcte_pkg::OP_WIDE) begin
                if (w == rvcte_pkg::EBREAK_WORD) begin
                    r.kind = rvcte_pkg::K_EBREAK;
                end
                else begin
                    case (w[6:0])
                        rvcte_pkg::OP_AUIPC: begin
                            r.kind = rvcte_pkg::K_AUIPC;
                            r.wr = 1'b1;
                            r.rd = w[11:7];
                            r.value = it.pc + {{32{w[31]}}, w[31:12], 12'd0};
                        end
                        rvcte_pkg::OP_JAL: begin
                            r.kind = rvcte_pkg::K_JAL;
                            r.wr = 1'b1;
                            r.rd = w[11:7];
                            r.value = seq_pc;
                            r.next_pc = it.pc
                                + {{44{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
                        end
                        rvcte_pkg::OP_JALR: begin
                            r.kind = rvcte_pkg::K_JALR;
                            r.wr = 1'b1;
                            r.rd = w[11:7];
                            r.value = seq_pc;
                            r.next_pc = (it.src1 + {{52{w[31]}}, w[31:20]}) & ~64'd1;
                        end
                        rvcte_pkg::OP_BRANCH: begin
                            r.kind = rvcte_pkg::K_BRANCH;
                            case (w[14:12])
                                rvcte_pkg::F3_BEQ:
                                    r.taken = (it.src1 == it.src2);
                                rvcte_pkg::F3_BNE:
                                    r.taken = (it.src1 != it.src2);
                                rvcte_pkg::F3_BLT:
                                    r.taken = ($signed(it.src1) < $signed(it.src2));
                                rvcte_pkg::F3_BGE:
                                    r.taken = ($signed(it.src1) >= $signed(it.src2));
                                rvcte_pkg::F3_BLTU:
                                    r.taken = (it.src1 < it.src2);
                                rvcte_pkg::F3_BGEU:
                                    r.taken = (it.src1 >= it.src2);
                                default:
                                    r.taken = 1'b0;
                            endcase
                            if (r.taken) begin
                                r.next_pc = it.pc
                                    + {{52{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            else if (h == rvcte_pkg::C_EBREAK_HW) begin
                r.kind = rvcte_pkg::K_EBREAK;
            end
            else if (h[1:0] == rvcte_pkg::C_OP_Q1 && h[15:13] == rvcte_pkg::C_F3_J) begin
                r.kind = rvcte_pkg::K_CJ;
                r.next_pc = it.pc + {{52{h[12]}}, h[12], h[8], h[10:9], h[6], h[7], h[2],
                                     h[11], h[5:3], 1'b0};
            end
            else if (h[1:0] == rvcte_pkg::C_OP_Q1 && (h[15:13] == rvcte_pkg::C_F3_BEQZ
                     || h[15:13] == rvcte_pkg::C_F3_BNEZ))
            begin
                r.kind = (h[15:13] == rvcte_pkg::C_F3_BEQZ) ? rvcte_pkg::K_CBEQZ
                                                            : rvcte_pkg::K_CBNEZ;
                r.taken = (r.kind == rvcte_pkg::K_CBEQZ) ? (it.src1 == 64'd0)
                                                         : (it.src1 != 64'd0);
                if (r.taken) begin
                    r.next_pc = it.pc
                        + {{55{h[12]}}, h[12], h[6:5], h[2], h[11:10], h[4:3], 1'b0};
                end
            end
            else if (h[1:0] == rvcte_pkg::C_OP_Q2 && h[15:13] == rvcte_pkg::C_F3_JR
                     && h[6:2] == rvcte_pkg::REG_ZERO && h[11:7] != rvcte_pkg::REG_ZERO) begin
                r.next_pc = it.src1 & ~64'd1;
                if (h[12]) begin
                    r.kind = rvcte_pkg::K_CJALR;
                    r.wr = 1'b1;
                    r.rd = rvcte_pkg::REG_RA;
                    r.value = seq_pc;
                end
                else begin
                    r.kind = rvcte_pkg::K_CJR;
                end
            end
            // A write to x0 reads as no write at all.
            if (!r.wr || r.rd == rvcte_pkg::REG_ZERO) begin
                r.wr = 1'b0;
                r.rd = rvcte_pkg::REG_ZERO;
                r.value = 64'd0;
            end
            return r;
        endfunction

        function void note_input(xfer_in_t it);
            pending_xfer_t p;
            p.res = resolve_transfer(it);
            p.word = it.word;
            expected_results.push_back(p);
            accepted++;
        endfunction

        task check_result(xfer_res_t got);
            pending_xfer_t p;
            if (expected_results.size() == 0) begin
                report("result item arrived with no instruction pending");
                return;
            end
            p = expected_results.pop_front();
            checked++;
            kind_hits[int'(p.res.kind)]++;
            if (p.res.taken) taken_seen++;
            if (p.res.wr) writes_seen++;
            if (got.kind !== p.res.kind)
                report($sformatf("word %h: kind %0d, expected %0d",
                                 p.word, got.kind, p.res.kind));
            if (got.len !== p.res.len)
                report($sformatf("word %h: inst_len %0d, expected %0d",
                                 p.word, got.len, p.res.len));
            if (got.next_pc !== p.res.next_pc)
                report($sformatf("word %h: next_pc %h, expected %h",
                                 p.word, got.next_pc, p.res.next_pc));
            if (got.taken !== p.res.taken)
                report($sformatf("word %h: branch_taken %b, expected %b",
                                 p.word, got.taken, p.res.taken));
            if (got.wr !== p.res.wr)
                report($sformatf("word %h: reg_write %b, expected %b",
                                 p.word, got.wr, p.res.wr));
            if (got.rd !== p.res.rd)
                report($sformatf("word %h: reg_index %0d, expected %0d",
                                 p.word, got.rd, p.res.rd));
            if (got.value !== p.res.value)
                report($sformatf("word %h: reg_value %h, expected %h",
                                 p.word, got.value, p.res.value));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] instruction;
    logic [63:0] pc;
    logic [63:0] rs1_value;
    logic [63:0] rs2_value;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  kind;
    logic [2:0]  inst_len;
    logic [63:0] next_pc;
    logic        branch_taken;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [63:0] reg_value;

    transfer_scoreboard sb;
    bit steady_flow = 1'b0;
    int long_hold = 0;
    int input_stall_cycles = 0;

    rv64_control_transfer_emulator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .instruction  (instruction),
        .pc           (pc),
        .rs1_value    (rs1_value),
        .rs2_value    (rs2_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .inst_len     (inst_len),
        .next_pc      (next_pc),
        .branch_taken (branch_taken),
        .reg_write    (reg_write),
        .reg_index    (reg_index),
        .reg_value    (reg_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Instruction encoders; fields the block does not decode get random bits.
    function automatic logic [31:0] enc_jal(logic [4:0] rd, logic [20:0] off);
        return {off[20], off[10:1], off[11], off[19:12], rd, rvcte_pkg::OP_JAL};
    endfunction

    function automatic logic [31:0] enc_jalr(logic [4:0] rd, logic [2:0] f3, logic [11:0] imm);
        logic [31:0] r;
        r = $urandom();
        return {imm, r[19:15], f3, rd, rvcte_pkg::OP_JALR};
    endfunction

    function automatic logic [31:0] enc_branch(logic [2:0] f3, logic [12:0] off);
        logic [31:0] r;
        r = $urandom();
        return {off[12], off[10:5], r[24:20], r[19:15], f3, off[4:1], off[11],
                rvcte_pkg::OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_cj(logic [11:0] off);
        logic [31:0] r;
        r = $urandom();
        return {r[31:16], rvcte_pkg::C_F3_J, off[11], off[4], off[9:8], off[10], off[6],
                off[7], off[3:1], off[5], rvcte_pkg::C_OP_Q1};
    endfunction

    function automatic logic [31:0] enc_cb(logic [2:0] f3, logic [8:0] off);
        logic [31:0] r;
        r = $urandom();
        return {r[31:16], f3, off[8], off[4:3], r[2:0], off[7:6], off[2:1], off[5],
                rvcte_pkg::C_OP_Q1};
    endfunction

    function automatic logic [31:0] enc_cjr(logic link, logic [4:0] rs1);
        logic [31:0] r;
        r = $urandom();
        return {r[31:16], rvcte_pkg::C_F3_JR, link, rs1, rvcte_pkg::REG_ZERO,
                rvcte_pkg::C_OP_Q2};
    endfunction

    // Register values biased toward zero, sign boundaries and small numbers.
    function automatic logic [63:0] operand();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0: v = 64'd0;
            1: v = ALL_ONES;
            2: v = SIGN_BIT;
            3: v = ~SIGN_BIT;
            4: v = 64'($urandom_range(0, 15));
            default: ;
        endcase
        return v;
    endfunction

    // Mostly well-formed control transfers with random content, plus noise.
    function automatic xfer_in_t random_item();
        xfer_in_t    it;
        logic [31:0] r;
        int          pick;
        r = $urandom();
        pick = $urandom_range(0, 99);
        it.pc = operand();
        it.src1 = operand();
        it.src2 = ($urandom_range(0, 2) == 0) ? it.src1 : operand();
        if (pick < 8)
            it.word = r;
        else if (pick < 10)
            it.word = r[0] ? rvcte_pkg::EBREAK_WORD : {r[31:16], rvcte_pkg::C_EBREAK_HW};
        else if (pick < 20)
            it.word = {r[31:7], rvcte_pkg::OP_AUIPC};
        else if (pick < 30)
            it.word = {r[31:7], rvcte_pkg::OP_JAL};
        else if (pick < 40)
            it.word = {r[31:7], rvcte_pkg::OP_JALR};
        else if (pick < 62)
            it.word = {r[31:7], rvcte_pkg::OP_BRANCH};
        else if (pick < 70)
            it.word = enc_cj(r[11:0]);
        else if (pick < 84) begin
            it.word = enc_cb(r[20] ? rvcte_pkg::C_F3_BEQZ : rvcte_pkg::C_F3_BNEZ, r[8:0]);
            if (r[21]) it.src1 = 64'd0;
        end
        else if (pick < 96)
            it.word = enc_cjr(r[20], r[25:21]);
        else
            it.word = {r[31:1], 1'b0};
        return it;
    endfunction

    // Offers one instruction, after a random gap unless the flow is steady, and holds it until accepted.
    task automatic drive_instruction(input xfer_in_t it);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        instruction <= it.word;
        pc <= it.pc;
        rs1_value <= it.src1;
        rs2_value <= it.src2;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    // Result side: random stall before each item unless the flow is steady, with an occasional long hold-off.
    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            hold = steady_flow ? 0 : $urandom_range(0, 5);
            if (long_hold > 0) begin
                hold += long_hold;
                long_hold = 0;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // Observes both handshakes on the clock edge.
    always @(posedge clk)
    begin
        xfer_res_t got;
        if (rst_n === 1'b1) begin
            if (out_valid === 1'b1 && out_stall === 1'b0) begin
                got.kind = rvcte_pkg::kind_t'(kind);
                got.len = inst_len;
                got.next_pc = next_pc;
                got.taken = branch_taken;
                got.wr = reg_write;
                got.rd = reg_index;
                got.value = reg_value;
                sb.check_result(got);
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
                sb.note_input(xfer_in_t'{instruction, pc, rs1_value, rs2_value});
            if (in_valid === 1'b1 && in_stall === 1'b1)
                input_stall_cycles++;
        end
    end

    // Main sequence: reset, directed cases, random instructions, drain.
    initial
    begin
        xfer_in_t directed[$];
        string    hist;
        int       spin;
        sb = new();
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        instruction <= 32'd0;
        pc <= 64'd0;
        rs1_value <= 64'd0;
        rs2_value <= 64'd0;
        out_stall <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes, every kind, and the special cases of the decode.
        directed.push_back(xfer_in_t'{rvcte_pkg::EBREAK_WORD, ALL_ONES, 64'd0, 64'd0});
        directed.push_back(xfer_in_t'{{16'hffff, rvcte_pkg::C_EBREAK_HW}, ALL_ONES - 1,
                                      64'd0, 64'd0});
        directed.push_back(xfer_in_t'{32'hffff_ffff, ALL_ONES, ALL_ONES, ALL_ONES});
        directed.push_back(xfer_in_t'{32'h0000_0000, 64'd0, 64'd0, 64'd0});
        directed.push_back(xfer_in_t'{{20'hfffff, 5'd31, rvcte_pkg::OP_AUIPC}, 64'h1000,
                                      64'd0, 64'd0});
        directed.push_back(xfer_in_t'{{20'h80000, rvcte_pkg::REG_ZERO, rvcte_pkg::OP_AUIPC},
                                      SIGN_BIT, 64'd0, 64'd0});
        directed.push_back(xfer_in_t'{enc_jal(rvcte_pkg::REG_RA, 21'h100000), 64'd0,
                                      64'd0, 64'd0});
        directed.push_back(xfer_in_t'{enc_jal(rvcte_pkg::REG_ZERO, 21'h0ffffe), ALL_ONES,
                                      64'd0, 64'd0});
        directed.push_back(xfer_in_t'{enc_jalr(5'd5, 3'd0, 12'hfff), 64'h2000, 64'h8000,
                                      64'd0});
        // A jalr with nonzero funct3 still decodes as jalr.
        directed.push_back(xfer_in_t'{enc_jalr(rvcte_pkg::REG_ZERO, 3'd3, 12'h7ff), 64'h10,
                                      ALL_ONES, 64'd0});
        // All eight branch funct3 codes, two of them unused; signed and unsigned orders disagree here.
        for (int i = 0; i < 8; i++)
            directed.push_back(xfer_in_t'{enc_branch(i[2:0], 13'h1000), 64'h4000, SIGN_BIT,
                                          64'd1});
        directed.push_back(xfer_in_t'{enc_branch(rvcte_pkg::F3_BEQ, 13'h0ffe), ALL_ONES,
                                      ALL_ONES, ALL_ONES});
        directed.push_back(xfer_in_t'{enc_cj(12'h800), 64'd0, 64'd0, 64'd0});
        directed.push_back(xfer_in_t'{enc_cj(12'h7fe), ALL_ONES, 64'd0, 64'd0});
        directed.push_back(xfer_in_t'{enc_cb(rvcte_pkg::C_F3_BEQZ, 9'h100), 64'h100,
                                      64'd0, 64'd0});
        directed.push_back(xfer_in_t'{enc_cb(rvcte_pkg::C_F3_BNEZ, 9'h0fe), 64'h100,
                                      64'd0, 64'd0});
        directed.push_back(xfer_in_t'{enc_cb(rvcte_pkg::C_F3_BNEZ, 9'h0fe), 64'h100,
                                      ALL_ONES, 64'd0});
        directed.push_back(xfer_in_t'{enc_cjr(1'b0, 5'd5), 64'h200, 64'h1235, 64'd0});
        directed.push_back(xfer_in_t'{enc_cjr(1'b1, 5'd31), 64'h200, ALL_ONES, 64'd0});
        // A jump-register form naming x0 is not a jump.
        directed.push_back(xfer_in_t'{enc_cjr(1'b0, rvcte_pkg::REG_ZERO), 64'h200, 64'h40,
                                      64'd0});
        foreach (directed[i])
            drive_instruction(directed[i]);

        // Random part; some windows run without idling, two of them with a long hold-off.
        for (int i = 0; i < 1950; i++) begin
            steady_flow = ((i / 150) % 3 == 1);
            if (i == 150 || i == 1050)
                long_hold = 60;
            drive_instruction(random_item());
        end
        in_valid <= 1'b0;
        steady_flow = 1'b0;

        // Drain the pipeline, then keep clocking to catch stray results.
        spin = 0;
        while (sb.expected_results.size() != 0 && spin < 5000) begin
            @(posedge clk);
            spin++;
        end
        repeat (10) @(posedge clk);
        if (sb.expected_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_results.size()));

        hist = "";
        for (int k = 0; k <= int'(rvcte_pkg::K_CJALR); k++)
            hist = {hist, $sformatf(" %0d", sb.kind_hits[k])};
        $display("Checked %0d results for %0d instructions: %0d taken branches, %0d writes.",
                 sb.checked, sb.accepted, sb.taken_seen, sb.writes_seen);
        $display("Input stalled for %0d cycles; results per kind, other through c.jalr:%s",
                 input_stall_cycles, hist);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
